### rtl/rgba_over_blend_defines.svh
// ---------------------------------------------------------------------------
// rgba_over_blend_defines: assertion macros for the over compositor
// ---------------------------------------------------------------------------
`ifndef RGBA_OVER_BLEND_DEFINES_SVH
`define RGBA_OVER_BLEND_DEFINES_SVH

// same-cycle implication, quiet during reset
`define ROB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rob_checker: same-cycle check failed");

// next-cycle implication, quiet during reset
`define ROB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rob_checker: next-cycle check failed");

// check that holds while reset is asserted
`define ROB_ASSERT_RESET(label, clk, rst_n, cons) \
    label: assert property (@(posedge clk) (!rst_n) |-> (cons)) \
        else $error("rob_checker: reset check failed");

`endif

### rtl/rob_pkg.sv
// ---------------------------------------------------------------------------
// rob_pkg: shared types and constants of the over compositor
// Pixel layout, lane count, pipeline depth and the stage payload structs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rob_pkg;

    localparam int PIX_W      = 32;
    localparam int CHAN_W     = 8;
    localparam int NUM_LANES  = 3;             // r, g, b
    localparam int WEIGHT_W   = 16;            // holds 255*255
    localparam int NUM_W      = WEIGHT_W + CHAN_W;
    localparam int QUOT_W     = CHAN_W;
    localparam int DIV_STAGES = QUOT_W;        // one quotient bit per stage
    // weight stage, numerator stage, divider stages, output register
    localparam int STAGES     = DIV_STAGES + 3;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    typedef logic [NUM_LANES-1:0][CHAN_W-1:0] chan_arr_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] fa;     // front alpha * 255
        logic [WEIGHT_W-1:0] bw;     // back alpha * (255 - front alpha)
        logic [WEIGHT_W-1:0] den;    // combined weight
    } weight_t;

    typedef struct packed {
        logic              zero;     // both alphas zero
        logic [CHAN_W-1:0] alpha;    // composite alpha
    } alpha_t;

    // color byte that feeds a lane: lane 0 is red in the top byte
    function automatic logic [CHAN_W-1:0] chan_byte(input logic [PIX_W-1:0] px,
                                                    input int lane);
        return px[CHAN_W*(NUM_LANES-lane) +: CHAN_W];
    endfunction

endpackage

### rtl/rob_weight.sv
// ---------------------------------------------------------------------------
// rob_weight: alpha weight stage
// Registers the front and back weights and color bytes, and derives the
// composite alpha from the combined weight.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rob_weight (
    input  logic                        clk,
    input  logic                        en,
    input  logic [rob_pkg::PIX_W-1:0]   front_pixel,
    input  logic [rob_pkg::PIX_W-1:0]   back_pixel,
    output rob_pkg::weight_t            weight,
    output rob_pkg::chan_arr_t          front_chan,
    output rob_pkg::chan_arr_t          back_chan,
    output rob_pkg::alpha_t             alpha_info
);
    import rob_pkg::*;

    logic [CHAN_W-1:0]   aa;
    logic [CHAN_W-1:0]   ab;
    weight_t             weight_next;
    weight_t             weight_reg;
    chan_arr_t           front_chan_next;
    chan_arr_t           back_chan_next;
    chan_arr_t           front_chan_reg;
    chan_arr_t           back_chan_reg;
    logic [WEIGHT_W-1:0] alpha_sum;

    assign aa = front_pixel[CHAN_W-1:0];
    assign ab = back_pixel[CHAN_W-1:0];

    // weights: aa*255 as a shift and subtract, one 8x8 product for the back
    always_comb
    begin
        weight_next.fa  = {aa, {CHAN_W{1'b0}}} - WEIGHT_W'(aa);
        weight_next.bw  = WEIGHT_W'(ab) * WEIGHT_W'(CHAN_MAX - aa);
        weight_next.den = weight_next.fa + weight_next.bw;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            front_chan_next[l] = chan_byte(front_pixel, l);
            back_chan_next[l]  = chan_byte(back_pixel, l);
        end
    end

    // stage register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            weight_reg     <= weight_next;
            front_chan_reg <= front_chan_next;
            back_chan_reg  <= back_chan_next;
        end
    end

    // den / 255 for den up to 255*255, where the 16-bit sum cannot wrap: (den + (den >> 8) + 1) >> 8
    assign alpha_sum = weight_reg.den + WEIGHT_W'(weight_reg.den[WEIGHT_W-1:CHAN_W])
                       + WEIGHT_W'(1);

    assign alpha_info.alpha = alpha_sum[WEIGHT_W-1:CHAN_W];
    assign alpha_info.zero  = (weight_reg.den == '0);

    assign weight     = weight_reg;
    assign front_chan = front_chan_reg;
    assign back_chan  = back_chan_reg;

endmodule

### rtl/rob_lane.sv
// ---------------------------------------------------------------------------
// rob_lane: one color channel lane
// Forms the weighted numerator, then divides it by the combined weight in
// a restoring divider pipeline that settles one quotient bit per stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rob_lane (
    input  logic                             clk,
    input  logic [rob_pkg::DIV_STAGES:0]     en,   // [0] numerator, [s+1] divider stage s
    input  logic [rob_pkg::CHAN_W-1:0]       front_chan,
    input  logic [rob_pkg::CHAN_W-1:0]       back_chan,
    input  rob_pkg::weight_t                 weight,
    output logic [rob_pkg::QUOT_W-1:0]       quot
);
    import rob_pkg::*;

    logic [NUM_W-1:0]    num_next;
    // rem_reg[0] / den_reg[0] come from the numerator stage,
    // rem_reg[s+1] / den_reg[s+1] from divider stage s
    logic [NUM_W-1:0]    rem_reg [DIV_STAGES];
    logic [WEIGHT_W-1:0] den_reg [DIV_STAGES];
    logic [QUOT_W-1:0]   q_reg   [DIV_STAGES];

    // numerator: ca*fa + cb*bw, never beyond 255 * den
    assign num_next = NUM_W'(front_chan) * NUM_W'(weight.fa)
                    + NUM_W'(back_chan) * NUM_W'(weight.bw);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0] <= num_next;
            den_reg[0] <= weight.den;
        end
    end

    // divider stages, msb first
    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        localparam int B = QUOT_W - 1 - s;

        logic [NUM_W-1:0]  dsh;
        logic              ge;
        logic [QUOT_W-1:0] q_in;
        logic [QUOT_W-1:0] q_next;

        assign dsh = NUM_W'(den_reg[s]) << B;
        assign ge  = (rem_reg[s] >= dsh);

        if (s == 0)
        begin : g_first
            assign q_in = '0;
        end
        else
        begin : g_rest
            assign q_in = q_reg[s-1];
        end

        always_comb
        begin
            q_next    = q_in;
            q_next[B] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (en[s+1])
            begin
                q_reg[s] <= q_next;
            end
        end

        // partial remainder and divisor move on, except after the last bit
        if (s < DIV_STAGES - 1)
        begin : g_rem
            logic [NUM_W-1:0] rem_next;

            assign rem_next = ge ? (rem_reg[s] - dsh) : rem_reg[s];

            always_ff @(posedge clk)
            begin
                if (en[s+1])
                begin
                    rem_reg[s+1] <= rem_next;
                    den_reg[s+1] <= den_reg[s];
                end
            end
        end
    end

    assign quot = q_reg[DIV_STAGES-1];

endmodule

### rtl/rob_merge.sv
// ---------------------------------------------------------------------------
// rob_merge: lane merge and output register
// Carries the composite alpha alongside the lanes and packs the channel
// quotients and alpha into the result pixel, zero when both alphas are zero.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rob_merge (
    input  logic                              clk,
    input  logic [rob_pkg::DIV_STAGES+1:0]    en,   // [0..DIV_STAGES] delay, top bit output
    input  rob_pkg::alpha_t                   alpha_info,
    input  rob_pkg::chan_arr_t                quot,
    output logic [rob_pkg::PIX_W-1:0]         blended_pixel
);
    import rob_pkg::*;

    localparam int DLY = DIV_STAGES + 1;

    alpha_t             alpha_reg [DLY];
    logic [PIX_W-1:0]   pixel_next;
    logic [PIX_W-1:0]   pixel_reg;

    // alpha delay line, in step with the numerator and divider stages
    for (genvar k = 0; k < DLY; k++)
    begin : g_dly
        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                alpha_reg[k] <= (k == 0) ? alpha_info : alpha_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    // pack lanes, lane 0 (red) in the top byte
    always_comb
    begin
        pixel_next = '0;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            pixel_next[PIX_W-1-CHAN_W*l -: CHAN_W] = quot[l];
        end
        pixel_next[CHAN_W-1:0] = alpha_reg[DLY-1].alpha;
        if (alpha_reg[DLY-1].zero)
        begin
            pixel_next = '0;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (en[DLY])
        begin
            pixel_reg <= pixel_next;
        end
    end

    assign blended_pixel = pixel_reg;

endmodule

### rtl/rgba_over_blend.sv
// ---------------------------------------------------------------------------
// rgba_over_blend: Porter-Duff over composite of straight-alpha RGBA8888
// Takes one front/back pixel pair per clock while not stalled and returns
// its exact integer over composite, with results in order: the weight
// stage loads at acceptance, then one numerator stage, eight divider stages
// (one quotient bit each) and the output register. Three channel lanes run
// side by side and merge with the alpha at the output. Each stage holds its
// transaction until the next one frees up, so input stalls only when the
// whole pipeline is full and the output is held back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgba_over_blend (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [rob_pkg::PIX_W-1:0]   front_pixel,
    input  logic [rob_pkg::PIX_W-1:0]   back_pixel,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [rob_pkg::PIX_W-1:0]   blended_pixel
);
    import rob_pkg::*;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] stage_en;
    weight_t           weight;
    chan_arr_t         front_chan;
    chan_arr_t         back_chan;
    alpha_t            alpha_info;
    chan_arr_t         quot;

    // a stage loads when it is empty or its successor loads
    always_comb
    begin
        stage_en[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    // transaction valid bits follow the payload
    always_comb
    begin
        valid_next = valid_reg;
        for (int k = 0; k < STAGES; k++)
        begin
            if (stage_en[k])
            begin
                valid_next[k] = (k == 0) ? in_valid : valid_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = stage_en[0];
    assign out_valid = valid_reg[STAGES-1];

    // weight stage
    rob_weight u_weight (
        .clk         (clk),
        .en          (stage_en[0]),
        .front_pixel (front_pixel),
        .back_pixel  (back_pixel),
        .weight      (weight),
        .front_chan  (front_chan),
        .back_chan   (back_chan),
        .alpha_info  (alpha_info)
    );

    // color lanes
    for (genvar l = 0; l < NUM_LANES; l++)
    begin : g_lane
        rob_lane u_lane (
            .clk        (clk),
            .en         (stage_en[DIV_STAGES+1:1]),
            .front_chan (front_chan[l]),
            .back_chan  (back_chan[l]),
            .weight     (weight),
            .quot       (quot[l])
        );
    end

    // merge and output register
    rob_merge u_merge (
        .clk           (clk),
        .en            (stage_en[STAGES-1:1]),
        .alpha_info    (alpha_info),
        .quot          (quot),
        .blended_pixel (blended_pixel)
    );

endmodule

### rtl/rob_checker.sv
// ---------------------------------------------------------------------------
// rob_checker: port-level checks of the over compositor
// Watches the handshakes of the top level and is bound to it below.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rgba_over_blend_defines.svh"

module rob_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_ready,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [rob_pkg::PIX_W-1:0]   blended_pixel
);
    // no result transaction offered while in reset
    `ROB_ASSERT_RESET(a_no_out_in_reset, clk, rst_n, !out_valid)

    // input only stalls while a result is held back
    `ROB_ASSERT_SAME(a_ready_unless_blocked, clk, rst_n, (!out_valid || out_ready), in_ready)

    // a held result stays offered
    `ROB_ASSERT_NEXT(a_out_valid_hold, clk, rst_n, (out_valid && !out_ready), out_valid)

    // a held result keeps its value
    `ROB_ASSERT_NEXT(a_out_data_hold, clk, rst_n, (out_valid && !out_ready), $stable(blended_pixel))

endmodule

bind rgba_over_blend rob_checker u_rob_checker (.*);
